[hw/rtl/gf2_pkg.sv]
`timescale 1ns / 1ps

package gf2_pkg;

   // Operand and accumulator widths.
   localparam int AW     = 68;   // wide multiplicand (sums, gains)
   localparam int BW     = 40;   // narrow multiplier, five 8-bit digits
   localparam int DIGITS = 5;
   localparam int ACCW   = 112;  // product accumulator and divider width
   localparam int QW     = 36;   // rounded quotient with cap flag bits

   // Microprogram: ten pairs of products, two steps per pair.
   localparam int NUM_STEPS = 20;
   localparam int DIV_STEPS = 36;

   localparam logic [3:0] PAIR_DET = 4'd0;
   localparam logic [3:0] PAIR_K00 = 4'd1;
   localparam logic [3:0] PAIR_K01 = 4'd2;
   localparam logic [3:0] PAIR_K10 = 4'd3;
   localparam logic [3:0] PAIR_K11 = 4'd4;
   localparam logic [3:0] PAIR_MX  = 4'd5;
   localparam logic [3:0] PAIR_MY  = 4'd6;
   localparam logic [3:0] PAIR_CXX = 4'd7;
   localparam logic [3:0] PAIR_CXY = 4'd8;
   localparam logic [3:0] PAIR_CYY = 4'd9;

   // Largest rounded quotient magnitude that is ever added.
   localparam logic [QW-1:0] CAP_MAG = QW'(1) << (QW - 2);

   typedef enum logic [3:0] {
      A_SXX, A_SXY, A_SYY, A_A, A_B, A_D, A_K00, A_K01, A_K10, A_K11
   } a_sel_type;

   typedef enum logic [2:0] {
      B_SXX, B_SXY, B_SYY, B_DX, B_DY, B_A, B_B, B_D
   } b_sel_type;

   typedef struct packed {
      a_sel_type a_sel;
      b_sel_type b_sel;
      logic      neg;
   } mac_op_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic       take;
      logic       mac_en;
      logic [4:0] step;
      logic [2:0] digit;
      logic       div_step;
      logic       q_store;
      logic       commit;
      logic       out_load;
      logic       out_sing;
   } cmd_type;

   typedef struct packed {
      logic det_zero;
   } status_type;

   // Operands of each product step. The second product of a pair is
   // subtracted for the determinant and the gain entries.
   function automatic mac_op_type mac_op(input logic [4:0] step);
      mac_op_type op;
      logic       second;
      second = step[0];
      op.neg = 1'b0;
      case (step[4:1])
         PAIR_DET: begin
            op.a_sel = second ? A_SXY : A_SXX;
            op.b_sel = second ? B_SXY : B_SYY;
            op.neg   = second;
         end
         PAIR_K00: begin
            op.a_sel = second ? A_B : A_A;
            op.b_sel = second ? B_SXY : B_SYY;
            op.neg   = second;
         end
         PAIR_K01: begin
            op.a_sel = second ? A_A : A_B;
            op.b_sel = second ? B_SXY : B_SXX;
            op.neg   = second;
         end
         PAIR_K10: begin
            op.a_sel = second ? A_D : A_B;
            op.b_sel = second ? B_SXY : B_SYY;
            op.neg   = second;
         end
         PAIR_K11: begin
            op.a_sel = second ? A_B : A_D;
            op.b_sel = second ? B_SXY : B_SXX;
            op.neg   = second;
         end
         PAIR_MX: begin
            op.a_sel = second ? A_K01 : A_K00;
            op.b_sel = second ? B_DY : B_DX;
         end
         PAIR_MY: begin
            op.a_sel = second ? A_K11 : A_K10;
            op.b_sel = second ? B_DY : B_DX;
         end
         PAIR_CXX: begin
            op.a_sel = second ? A_K01 : A_K00;
            op.b_sel = second ? B_B : B_A;
         end
         PAIR_CXY: begin
            op.a_sel = second ? A_K01 : A_K00;
            op.b_sel = second ? B_D : B_B;
         end
         PAIR_CYY: begin
            op.a_sel = second ? A_K11 : A_K10;
            op.b_sel = second ? B_D : B_B;
         end
         default: begin
            op.a_sel = A_SXX;
            op.b_sel = B_SXX;
         end
      endcase
      return op;
   endfunction

   // Clamp a sum to the signed 32-bit range.
   function automatic logic [31:0] sat32(input logic signed [QW:0] v);
      logic [31:0] r;
      if ((&v[QW:31]) || !(|v[QW:31])) begin
         r = v[31:0];
      end else if (v[QW]) begin
         r = 32'h8000_0000;
      end else begin
         r = 32'h7fff_ffff;
      end
      return r;
   endfunction

endpackage

[hw/rtl/gaussian_fusion_2d.sv]
`timescale 1ns / 1ps
// Channel   Direction  Handshake             Payload
// req       in         req_valid/req_stall   req_type, req_in_mean_*, req_in_cov_*
// rsp       out        rsp_valid/rsp_stall   rsp_est_mean_*, rsp_est_cov_*, rsp_singular
//
// A load transaction replaces the estimate. A fuse transaction runs 20 products,
// each fed one 8-bit digit at a time to one 68x9-bit multiplier with accumulator,
// then 5 restoring divisions; a singular fuse ends after the determinant pair.
// Reset is synchronous and clears the estimate to zero.
// One transaction is in work at a time; a new one is taken while the previous
// result still waits in the output register under rsp_stall.

module gaussian_fusion_2d import gf2_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_type,
   input  logic signed [31:0] req_in_mean_x,
   input  logic signed [31:0] req_in_mean_y,
   input  logic signed [31:0] req_in_cov_xx,
   input  logic signed [31:0] req_in_cov_xy,
   input  logic signed [31:0] req_in_cov_yy,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_est_mean_x,
   output logic signed [31:0] rsp_est_mean_y,
   output logic signed [31:0] rsp_est_cov_xx,
   output logic signed [31:0] rsp_est_cov_xy,
   output logic signed [31:0] rsp_est_cov_yy,
   output logic               rsp_singular
);

   cmd_type    cmd;
   status_type status;

   // Sequencer.
   gf2_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_type  (req_type),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // Estimate, multiplier, divider and result register.
   gf2_datapath u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_type       (req_type),
      .req_in_mean_x  (req_in_mean_x),
      .req_in_mean_y  (req_in_mean_y),
      .req_in_cov_xx  (req_in_cov_xx),
      .req_in_cov_xy  (req_in_cov_xy),
      .req_in_cov_yy  (req_in_cov_yy),
      .rsp_est_mean_x (rsp_est_mean_x),
      .rsp_est_mean_y (rsp_est_mean_y),
      .rsp_est_cov_xx (rsp_est_cov_xx),
      .rsp_est_cov_xy (rsp_est_cov_xy),
      .rsp_est_cov_yy (rsp_est_cov_yy),
      .rsp_singular   (rsp_singular)
   );

endmodule

[hw/rtl/gf2_datapath.sv]
`timescale 1ns / 1ps

module gf2_datapath import gf2_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  cmd_type            cmd,
   output status_type         status,
   input  logic               req_type,
   input  logic signed [31:0] req_in_mean_x,
   input  logic signed [31:0] req_in_mean_y,
   input  logic signed [31:0] req_in_cov_xx,
   input  logic signed [31:0] req_in_cov_xy,
   input  logic signed [31:0] req_in_cov_yy,
   output logic signed [31:0] rsp_est_mean_x,
   output logic signed [31:0] rsp_est_mean_y,
   output logic signed [31:0] rsp_est_cov_xx,
   output logic signed [31:0] rsp_est_cov_xy,
   output logic signed [31:0] rsp_est_cov_yy,
   output logic               rsp_singular
);

   logic signed [31:0]     mean_x_ff, mean_y_ff, cov_xx_ff, cov_xy_ff, cov_yy_ff;
   logic signed [32:0]     sxx_ff, sxy_ff, syy_ff, dx_ff, dy_ff;
   logic signed [AW-1:0]   det_ff, k00_ff, k01_ff, k10_ff, k11_ff;
   logic signed [ACCW-1:0] acc_ff;
   logic [ACCW-1:0]        rem_ff, den_ff;
   logic [QW-1:0]          q_ff;
   logic                   neg_ff;
   logic signed [QW-1:0]   dmx_ff, dmy_ff, dcxx_ff, dcxy_ff, dcyy_ff;

   mac_op_type             op;
   logic [3:0]             pair;
   logic                   last_in;
   logic signed [AW-1:0]   a_opd;
   logic signed [BW-1:0]   b_opd;
   logic [5:0]             shamt;
   logic [7:0]             dig;
   logic signed [8:0]      dext;
   logic signed [AW+8:0]   part;
   logic signed [ACCW-1:0] shifted, term, acc_base, acc_in;
   logic [ACCW-1:0]        an, ad, rem_diff;
   logic signed [AW-1:0]   det_abs;
   logic                   ge;
   logic [QW-1:0]          mag;
   logic signed [QW-1:0]   delta;

   assign status.det_zero = (det_ff == '0);

   // Operand selection for the current product step.
   always_comb begin
      op      = mac_op(cmd.step);
      pair    = cmd.step[4:1];
      last_in = cmd.step[0] && (cmd.digit == 3'(DIGITS - 1));
      case (op.a_sel)
         A_SXX:   a_opd = AW'(sxx_ff);
         A_SXY:   a_opd = AW'(sxy_ff);
         A_SYY:   a_opd = AW'(syy_ff);
         A_A:     a_opd = AW'(cov_xx_ff);
         A_B:     a_opd = AW'(cov_xy_ff);
         A_D:     a_opd = AW'(cov_yy_ff);
         A_K00:   a_opd = k00_ff;
         A_K01:   a_opd = k01_ff;
         A_K10:   a_opd = k10_ff;
         A_K11:   a_opd = k11_ff;
         default: a_opd = '0;
      endcase
      case (op.b_sel)
         B_SXX:   b_opd = BW'(sxx_ff);
         B_SXY:   b_opd = BW'(sxy_ff);
         B_SYY:   b_opd = BW'(syy_ff);
         B_DX:    b_opd = BW'(dx_ff);
         B_DY:    b_opd = BW'(dy_ff);
         B_A:     b_opd = BW'(cov_xx_ff);
         B_B:     b_opd = BW'(cov_xy_ff);
         B_D:     b_opd = BW'(cov_yy_ff);
         default: b_opd = '0;
      endcase
   end

   // One 8-bit digit of the multiplier per cycle; the top digit is signed.
   always_comb begin
      shamt    = {cmd.digit, 3'b000};
      dig      = b_opd[shamt +: 8];
      dext     = (cmd.digit == 3'(DIGITS - 1)) ? {dig[7], dig} : {1'b0, dig};
      part     = a_opd * dext;
      shifted  = ACCW'(part) <<< shamt;
      term     = op.neg ? -shifted : shifted;
      acc_base = (cmd.digit == 3'd0 && !cmd.step[0]) ? '0 : acc_ff;
      acc_in   = acc_base + term;
   end

   // Divider setup from the finished numerator, and the restoring step.
   always_comb begin
      an       = acc_in[ACCW-1] ? ACCW'(-acc_in) : ACCW'(acc_in);
      det_abs  = det_ff[AW-1] ? -det_ff : det_ff;
      ad       = ACCW'(unsigned'(det_abs));
      ge       = (rem_ff >= den_ff);
      rem_diff = rem_ff - den_ff;
      mag      = (q_ff[QW-1] || q_ff[QW-2]) ? CAP_MAG : {2'b00, q_ff[QW-3:0]};
      delta    = neg_ff ? -signed'(mag) : signed'(mag);
   end

   // Estimate state: replaced by a load, updated at commit.
   always_ff @(posedge clock) begin
      if (reset) begin
         mean_x_ff <= '0;
         mean_y_ff <= '0;
         cov_xx_ff <= '0;
         cov_xy_ff <= '0;
         cov_yy_ff <= '0;
      end else if (cmd.take && !req_type) begin
         mean_x_ff <= req_in_mean_x;
         mean_y_ff <= req_in_mean_y;
         cov_xx_ff <= req_in_cov_xx;
         cov_xy_ff <= req_in_cov_xy;
         cov_yy_ff <= req_in_cov_yy;
      end else if (cmd.commit) begin
         mean_x_ff <= sat32((QW+1)'(mean_x_ff) + (QW+1)'(dmx_ff));
         mean_y_ff <= sat32((QW+1)'(mean_y_ff) + (QW+1)'(dmy_ff));
         cov_xx_ff <= sat32((QW+1)'(cov_xx_ff) - (QW+1)'(dcxx_ff));
         cov_xy_ff <= sat32((QW+1)'(cov_xy_ff) - (QW+1)'(dcxy_ff));
         cov_yy_ff <= sat32((QW+1)'(cov_yy_ff) - (QW+1)'(dcyy_ff));
      end
   end

   // Summed covariance and mean differences of a fuse transaction.
   always_ff @(posedge clock) begin
      if (cmd.take) begin
         sxx_ff <= 33'(cov_xx_ff) + 33'(req_in_cov_xx);
         sxy_ff <= 33'(cov_xy_ff) + 33'(req_in_cov_xy);
         syy_ff <= 33'(cov_yy_ff) + 33'(req_in_cov_yy);
         dx_ff  <= 33'(req_in_mean_x) - 33'(mean_x_ff);
         dy_ff  <= 33'(req_in_mean_y) - 33'(mean_y_ff);
      end
   end

   // Accumulator, product results and divider.
   always_ff @(posedge clock) begin
      if (cmd.mac_en) begin
         acc_ff <= acc_in;
         if (last_in) begin
            case (pair)
               PAIR_DET: det_ff <= acc_in[AW-1:0];
               PAIR_K00: k00_ff <= acc_in[AW-1:0];
               PAIR_K01: k01_ff <= acc_in[AW-1:0];
               PAIR_K10: k10_ff <= acc_in[AW-1:0];
               PAIR_K11: k11_ff <= acc_in[AW-1:0];
               default: begin
                  rem_ff <= (an << 1) + ad;
                  den_ff <= ad << QW;
                  q_ff   <= '0;
                  neg_ff <= acc_in[ACCW-1] ^ det_ff[AW-1];
               end
            endcase
         end
      end
      if (cmd.div_step) begin
         rem_ff <= ge ? rem_diff : rem_ff;
         q_ff   <= {q_ff[QW-2:0], ge};
         den_ff <= den_ff >> 1;
      end
      if (cmd.q_store) begin
         case (pair)
            PAIR_MX:  dmx_ff  <= delta;
            PAIR_MY:  dmy_ff  <= delta;
            PAIR_CXX: dcxx_ff <= delta;
            PAIR_CXY: dcxy_ff <= delta;
            PAIR_CYY: dcyy_ff <= delta;
            default:  dmx_ff  <= dmx_ff;
         endcase
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_est_mean_x <= mean_x_ff;
         rsp_est_mean_y <= mean_y_ff;
         rsp_est_cov_xx <= cov_xx_ff;
         rsp_est_cov_xy <= cov_xy_ff;
         rsp_est_cov_yy <= cov_yy_ff;
         rsp_singular   <= cmd.out_sing;
      end
   end

endmodule

[hw/rtl/gf2_controller.sv]
`timescale 1ns / 1ps

module gf2_controller import gf2_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic       req_type,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [2:0] {
      S_IDLE, S_MUL, S_CHK, S_DIV, S_QST, S_COMMIT, S_DONE
   } state_type;

   state_type  state_ff;
   logic [4:0] step_ff;
   logic [2:0] digit_ff;
   logic [5:0] divcnt_ff;
   logic       sing_ff;
   logic       rsp_valid_ff;
   logic       take;
   logic       out_fire;
   logic [3:0] pair;

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign take      = req_valid && (state_ff == S_IDLE);
   assign out_fire  = (state_ff == S_DONE) && (!rsp_valid_ff || !rsp_stall);
   assign pair      = step_ff[4:1];

   // Commands decoded from the state and counters.
   always_comb begin
      cmd.take     = take;
      cmd.mac_en   = (state_ff == S_MUL);
      cmd.step     = step_ff;
      cmd.digit    = digit_ff;
      cmd.div_step = (state_ff == S_DIV);
      cmd.q_store  = (state_ff == S_QST);
      cmd.commit   = (state_ff == S_COMMIT);
      cmd.out_load = out_fire;
      cmd.out_sing = sing_ff;
   end

   // Sequencer and result handshake.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         step_ff      <= '0;
         digit_ff     <= '0;
         divcnt_ff    <= '0;
         sing_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (out_fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (take) begin
                  sing_ff  <= 1'b0;
                  step_ff  <= '0;
                  digit_ff <= '0;
                  state_ff <= req_type ? S_MUL : S_DONE;
               end
            end
            S_MUL: begin
               if (digit_ff == 3'(DIGITS - 1)) begin
                  digit_ff <= '0;
                  if (step_ff[0] && pair == PAIR_DET) begin
                     state_ff <= S_CHK;
                  end else if (step_ff[0] && pair >= PAIR_MX) begin
                     divcnt_ff <= '0;
                     state_ff  <= S_DIV;
                  end else begin
                     step_ff <= step_ff + 5'd1;
                  end
               end else begin
                  digit_ff <= digit_ff + 3'd1;
               end
            end
            S_CHK: begin
               if (status.det_zero) begin
                  sing_ff  <= 1'b1;
                  state_ff <= S_DONE;
               end else begin
                  step_ff  <= step_ff + 5'd1;
                  state_ff <= S_MUL;
               end
            end
            S_DIV: begin
               if (divcnt_ff == 6'(DIV_STEPS - 1)) begin
                  state_ff <= S_QST;
               end else begin
                  divcnt_ff <= divcnt_ff + 6'd1;
               end
            end
            S_QST: begin
               if (step_ff == 5'(NUM_STEPS - 1)) begin
                  state_ff <= S_COMMIT;
               end else begin
                  step_ff  <= step_ff + 5'd1;
                  state_ff <= S_MUL;
               end
            end
            S_COMMIT: begin
               state_ff <= S_DONE;
            end
            S_DONE: begin
               if (out_fire) begin
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

endmodule
